@@ design/png_chk_pkg.sv @@
// ----------------------------------------------------------------------------
// png_chk_pkg
// Shared constants and the result record for the PNG chunk structure checker.
// ----------------------------------------------------------------------------
package png_chk_pkg;

  // width of the internal file position counter (16 to 64)
  localparam int OFFSET_BITS = 32;

  // fixed words of the file format
  localparam logic [63:0] SIG_WORD = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TYPE_HDR = 32'h49484452;
  localparam logic [31:0] TYPE_DAT = 32'h49444154;
  localparam logic [31:0] TYPE_END = 32'h49454E44;
  localparam logic [31:0] HDR_LEN  = 32'd13;

  // report kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // verdict codes
  typedef enum logic [2:0] {
    V_OK       = 3'd0,
    V_BAD_SIG  = 3'd1,
    V_BAD_HDR  = 3'd2,
    V_NO_DATA  = 3'd3,
    V_BAD_END  = 3'd4
  } verdict_t;

  // one result record
  typedef struct packed {
    logic        report_kind;
    logic [2:0]  verdict;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_length;
    logic [31:0] chunk_crc;
    logic        run_end;
  } report_t;

endpackage

@@ design/png_chk_in_if.sv @@
// ----------------------------------------------------------------------------
// png_chk_in_if
// Byte channel into the checker: one file byte and a last-byte flag per item.
// ----------------------------------------------------------------------------
interface png_chk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

@@ design/png_chk_out_if.sv @@
// ----------------------------------------------------------------------------
// png_chk_out_if
// Result channel out of the checker: data chunk reports and final verdicts.
// ----------------------------------------------------------------------------
interface png_chk_out_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic [2:0]  verdict;
  logic [31:0] chunk_offset;
  logic [31:0] chunk_length;
  logic [31:0] chunk_crc;
  logic        run_end;

  modport source (output valid, output report_kind, output verdict,
                  output chunk_offset, output chunk_length, output chunk_crc,
                  output run_end, input ready);
  modport sink   (input valid, input report_kind, input verdict,
                  input chunk_offset, input chunk_length, input chunk_crc,
                  input run_end, output ready);
endinterface

@@ design/png_chunk_structure_checker_unit.sv @@
// ----------------------------------------------------------------------------
// png_chunk_structure_checker_unit
// Walks a PNG file byte by byte, checks signature and chunk layout, reports
// every IDAT chunk (offset, length, CRC) and gives a verdict per file.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                          items
//  bytes     in   in_byte[7:0], final_byte                          1 per byte
//  reports   out  report_kind, verdict[2:0], chunk_offset[31:0],    0..2 per byte
//                 chunk_length[31:0], chunk_crc[31:0], run_end
//
//  One byte per cycle while the result queue has room: a byte waits in the
//  input register, the parser state updates as it leaves and its results
//  land in a 4-entry result queue that drains one item per cycle while
//  reports.ready is high. Results are read from the registered queue.
//  The input register advances only while the queue has room for two items;
//  a stalled result side therefore backs up into bytes.ready.
//  rst (synchronous) clears the parser to "expect signature"; the last byte
//  of each file does the same.
// ----------------------------------------------------------------------------
module png_chunk_structure_checker_unit (
  input  logic                 clk,
  input  logic                 rst,
  png_chk_in_if.sink           bytes,
  png_chk_out_if.source        reports
);
  import png_chk_pkg::*;

  typedef enum logic [3:0] {
    PH_SIG   = 4'd0,
    PH_HLEN  = 4'd1,
    PH_HTYPE = 4'd2,
    PH_SKIP  = 4'd3,
    PH_LEN   = 4'd4,
    PH_TYPE  = 4'd5,
    PH_DSKIP = 4'd6,
    PH_CRC   = 4'd7,
    PH_TAIL  = 4'd8
  } phase_t;

  localparam int QDEPTH = 4;
  localparam int QPTR   = $clog2(QDEPTH);
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_final;
  logic       advance;

  // parser state
  phase_t                 phase, phase_next;
  logic [2:0]             field_byte_count, field_byte_count_next;
  logic [63:0]            gather_word, gather_word_next;
  logic [32:0]            skip_count, skip_count_next;
  logic [OFFSET_BITS-1:0] file_position, file_position_next;
  logic [OFFSET_BITS-1:0] current_chunk_start, current_chunk_start_next;
  logic [31:0]            current_chunk_length, current_chunk_length_next;
  logic                   data_chunk_seen, data_chunk_seen_next;
  logic                   verdict_given, verdict_given_next;

  // results of the current byte
  logic       rep_fire;
  logic       ver_fire;
  verdict_t   ver_code;
  report_t    rep_item, ver_item, r0, r1;
  logic [1:0] push_n;

  // result queue
  report_t           q_mem [QDEPTH];
  logic [QPTR-1:0]   q_wr, q_rd;
  logic [QPTR:0]     q_count;
  logic              pop;

  // helpers
  logic [3:0]  cnt_p1;
  logic [63:0] gw_shift;
  logic [63:0] start_wide;
  logic [31:0] start_sat;

  assign advance     = s1_valid && (q_count <= (QPTR+1)'(QDEPTH - 2));
  assign bytes.ready = !s1_valid || advance;
  assign pop         = reports.valid && reports.ready;

  assign cnt_p1   = {1'b0, field_byte_count} + 4'd1;
  assign gw_shift = {gather_word[55:0], s1_byte};

  // saturate chunk start to 32 bits
  assign start_wide = 64'(current_chunk_start);
  assign start_sat  = (|start_wide[63:32]) ? 32'hFFFF_FFFF : start_wide[31:0];

  // parser step for the byte in the input register
  always_comb begin
    phase_next                = phase;
    field_byte_count_next     = field_byte_count;
    gather_word_next          = gather_word;
    skip_count_next           = skip_count;
    current_chunk_start_next  = current_chunk_start;
    current_chunk_length_next = current_chunk_length;
    data_chunk_seen_next      = data_chunk_seen;
    verdict_given_next        = verdict_given;
    rep_fire                  = 1'b0;
    ver_fire                  = 1'b0;
    ver_code                  = V_OK;

    file_position_next = (file_position != POS_MAX) ? file_position + 1'b1
                                                    : file_position;

    if (!verdict_given) begin
      case (phase)
        PH_SIG: begin
          gather_word_next      = gw_shift;
          field_byte_count_next = cnt_p1[2:0];
          if (cnt_p1 == 4'd8) begin
            field_byte_count_next = 3'd0;
            if (gw_shift != SIG_WORD) begin
              ver_fire = 1'b1;
              ver_code = V_BAD_SIG;
            end else begin
              phase_next       = PH_HLEN;
              gather_word_next = '0;
            end
          end
        end
        PH_HLEN: begin
          gather_word_next      = gw_shift;
          field_byte_count_next = cnt_p1[2:0];
          if (cnt_p1 == 4'd4) begin
            field_byte_count_next = 3'd0;
            if (gw_shift[31:0] != HDR_LEN) begin
              ver_fire = 1'b1;
              ver_code = V_BAD_HDR;
            end else begin
              phase_next       = PH_HTYPE;
              gather_word_next = '0;
            end
          end
        end
        PH_HTYPE: begin
          gather_word_next      = gw_shift;
          field_byte_count_next = cnt_p1[2:0];
          if (cnt_p1 == 4'd4) begin
            field_byte_count_next = 3'd0;
            if (gw_shift[31:0] != TYPE_HDR) begin
              ver_fire = 1'b1;
              ver_code = V_BAD_HDR;
            end else begin
              phase_next      = PH_SKIP;
              skip_count_next = 33'(HDR_LEN) + 33'd4;
            end
          end
        end
        PH_SKIP, PH_DSKIP: begin
          if (skip_count != '0) skip_count_next = skip_count - 1'b1;
          if (skip_count <= 33'd1) begin
            phase_next            = (phase == PH_SKIP) ? PH_LEN : PH_CRC;
            field_byte_count_next = 3'd0;
            gather_word_next      = '0;
          end
        end
        PH_LEN: begin
          if (field_byte_count == 3'd0) current_chunk_start_next = file_position;
          gather_word_next      = gw_shift;
          field_byte_count_next = cnt_p1[2:0];
          if (cnt_p1 == 4'd4) begin
            current_chunk_length_next = gw_shift[31:0];
            phase_next                = PH_TYPE;
            field_byte_count_next     = 3'd0;
            gather_word_next          = '0;
          end
        end
        PH_TYPE: begin
          gather_word_next      = gw_shift;
          field_byte_count_next = cnt_p1[2:0];
          if (cnt_p1 == 4'd4) begin
            field_byte_count_next = 3'd0;
            if (gw_shift[31:0] == TYPE_DAT) begin
              data_chunk_seen_next = 1'b1;
              skip_count_next      = {1'b0, current_chunk_length};
              if (current_chunk_length == '0) begin
                phase_next       = PH_CRC;
                gather_word_next = '0;
              end else begin
                phase_next = PH_DSKIP;
              end
            end else if (gw_shift[31:0] == TYPE_END) begin
              if (current_chunk_length != '0) begin
                ver_fire = 1'b1;
                ver_code = V_BAD_END;
              end else begin
                phase_next       = PH_TAIL;
                gather_word_next = '0;
              end
            end else begin
              phase_next      = PH_SKIP;
              skip_count_next = {1'b0, current_chunk_length} + 33'd4;
            end
          end
        end
        PH_CRC: begin
          gather_word_next      = gw_shift;
          field_byte_count_next = cnt_p1[2:0];
          if (cnt_p1 == 4'd4) begin
            rep_fire              = 1'b1;
            phase_next            = PH_LEN;
            field_byte_count_next = 3'd0;
            gather_word_next      = '0;
          end
        end
        PH_TAIL: begin
          field_byte_count_next = cnt_p1[2:0];
          if (cnt_p1 >= 4'd5) begin
            ver_fire = 1'b1;
            ver_code = V_BAD_END;
          end
        end
        default: begin
          ver_fire = 1'b1;
          ver_code = V_BAD_END;
        end
      endcase
    end

    if (ver_fire) verdict_given_next = 1'b1;

    // end of file: final verdict unless one was given, then restart
    if (s1_final) begin
      if (!verdict_given_next) begin
        ver_fire = 1'b1;
        if (phase_next == PH_SIG) begin
          ver_code = V_BAD_SIG;
        end else if (phase_next == PH_HLEN || phase_next == PH_HTYPE) begin
          ver_code = V_BAD_HDR;
        end else if (phase_next == PH_TAIL && field_byte_count_next == 3'd4) begin
          ver_code = data_chunk_seen_next ? V_OK : V_NO_DATA;
        end else begin
          ver_code = V_BAD_END;
        end
      end
      phase_next                = PH_SIG;
      field_byte_count_next     = '0;
      gather_word_next          = '0;
      skip_count_next           = '0;
      file_position_next        = '0;
      current_chunk_start_next  = '0;
      current_chunk_length_next = '0;
      data_chunk_seen_next      = 1'b0;
      verdict_given_next        = 1'b0;
    end
  end

  // build result items: data report first, verdict second
  always_comb begin
    rep_item.report_kind  = KIND_DATA;
    rep_item.verdict      = V_OK;
    rep_item.chunk_offset = start_sat;
    rep_item.chunk_length = current_chunk_length;
    rep_item.chunk_crc    = gw_shift[31:0];
    rep_item.run_end      = !ver_fire;

    ver_item.report_kind  = KIND_VERDICT;
    ver_item.verdict      = ver_code;
    ver_item.chunk_offset = '0;
    ver_item.chunk_length = '0;
    ver_item.chunk_crc    = '0;
    ver_item.run_end      = 1'b1;

    r0     = rep_fire ? rep_item : ver_item;
    r1     = ver_item;
    push_n = advance ? ({1'b0, rep_fire} + {1'b0, ver_fire}) : 2'd0;
  end

  // input register and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid             <= 1'b0;
      phase                <= PH_SIG;
      field_byte_count     <= '0;
      gather_word          <= '0;
      skip_count           <= '0;
      file_position        <= '0;
      current_chunk_start  <= '0;
      current_chunk_length <= '0;
      data_chunk_seen      <= 1'b0;
      verdict_given        <= 1'b0;
    end else begin
      if (bytes.valid && bytes.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        phase                <= phase_next;
        field_byte_count     <= field_byte_count_next;
        gather_word          <= gather_word_next;
        skip_count           <= skip_count_next;
        file_position        <= file_position_next;
        current_chunk_start  <= current_chunk_start_next;
        current_chunk_length <= current_chunk_length_next;
        data_chunk_seen      <= data_chunk_seen_next;
        verdict_given        <= verdict_given_next;
      end
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte  <= bytes.in_byte;
      s1_final <= bytes.final_byte;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      q_wr    <= q_wr + QPTR'(push_n);
      q_rd    <= q_rd + QPTR'(pop);
      q_count <= q_count + (QPTR+1)'(push_n) - (QPTR+1)'(pop);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_mem[q_wr] <= r0;
    if (push_n == 2'd2) q_mem[q_wr + 1'b1] <= r1;
  end

  // output side
  assign reports.valid        = (q_count != '0);
  assign reports.report_kind  = q_mem[q_rd].report_kind;
  assign reports.verdict      = q_mem[q_rd].verdict;
  assign reports.chunk_offset = q_mem[q_rd].chunk_offset;
  assign reports.chunk_length = q_mem[q_rd].chunk_length;
  assign reports.chunk_crc    = q_mem[q_rd].chunk_crc;
  assign reports.run_end      = q_mem[q_rd].run_end;

endmodule
